// ===== hw/rtl/mtc_pkg.sv =====
// Shared constants and types for the magnetometer trim compensation block.
package mtc_pkg;

  localparam int ADDR_W    = 5;
  localparam int DIV_NUM_W = 32;
  localparam int DIV_DEN_W = 17;

  localparam logic [2:0] REG_X_PAIR   = 3'd0;
  localparam logic [2:0] REG_Y_PAIR   = 3'd1;
  localparam logic [2:0] REG_XY_PAIR  = 3'd2;
  localparam logic [2:0] REG_Z_ONE    = 3'd3;
  localparam logic [2:0] REG_Z_TWO    = 3'd4;
  localparam logic [2:0] REG_Z_THREE  = 3'd5;
  localparam logic [2:0] REG_Z_FOUR   = 3'd6;
  localparam logic [2:0] REG_XYZ_ONE  = 3'd7;

  localparam logic [15:0]        TEMP_BIAS  = 16'h4000;
  localparam logic [31:0]        SENS_BIAS  = 32'h0010_0000;
  localparam logic signed [9:0]  GAIN_BIAS  = 10'sd160;
  localparam logic [31:0]        ROUND_HALF = 32'h0000_8000;

  typedef struct packed {
    logic               rdy;
    logic signed [12:0] mx;
    logic signed [12:0] my;
    logic               dr_zero;
    logic               z_neg;
    logic               den_zero;
  } side_t;

endpackage

// ===== hw/rtl/mtc_div.sv =====
// Pipelined restoring unsigned divider, one quotient bit per stage.
module mtc_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 17
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o
);

  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [NUM_W-1:0] n_r   [NUM_W];
  logic [NUM_W-1:0] q_r   [NUM_W];
  logic [DEN_W-1:0] d_r   [NUM_W];

  genvar k;
  generate
    for (k = 0; k < NUM_W; k++) begin : g_step
      logic [DEN_W-1:0] rem_in;
      logic [DEN_W-1:0] d_in;
      logic [NUM_W-1:0] n_in;
      logic [NUM_W-1:0] q_in;
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             ge;

      if (k == 0) begin : g_first
        assign rem_in = '0;
        assign d_in   = den_i;
        assign n_in   = num_i;
        assign q_in   = '0;
      end else begin : g_next
        assign rem_in = rem_r[k-1];
        assign d_in   = d_r[k-1];
        assign n_in   = n_r[k-1];
        assign q_in   = q_r[k-1];
      end

      assign trial = {rem_in, n_in[NUM_W-1]};
      assign diff  = trial - {1'b0, d_in};
      assign ge    = (trial >= {1'b0, d_in});

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
          n_r[k]   <= {n_in[NUM_W-2:0], 1'b0};
          q_r[k]   <= {q_in[NUM_W-2:0], ge};
          d_r[k]   <= d_in;
        end
      end
    end
  endgenerate

  assign quo_o = q_r[NUM_W-1];

endmodule

// ===== hw/rtl/magnetometer_trim_compensation_top.sv =====
// Top level of the magnetometer trim compensation pipeline with its trim registers.
//
//  port group | dir | handshake         | beat content
//  in_*       | in  | in_valid/in_ready | raw x, y, z and hall words
//  out_*      | out | out_valid/out_ready | ready flag, x, y, z fields, divide fault
//  APB        | in  | psel/penable      | eight 16-bit trim registers at 4*i
//
// One beat per cycle while the output is not stalled; three prep stages, two 32-stage
// dividers side by side, six post stages.
// Whole pipeline advances on one enable: it moves when the output is empty or taken.
// Synchronous active-low reset clears valid bits and trims; data regs are not reset.
module magnetometer_trim_compensation_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [15:0]                in_word_x,
  input  logic [15:0]                in_word_y,
  input  logic [15:0]                in_word_z,
  input  logic [15:0]                in_word_hall,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_ready_res,
  output logic signed [15:0]         out_field_x,
  output logic signed [15:0]         out_field_y,
  output logic signed [15:0]         out_field_z,
  output logic                       out_div_fault,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mtc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int LAT = mtc_pkg::DIV_NUM_W;

  // trim registers
  logic [15:0] x_pair_r, y_pair_r, xy_pair_r, z_one_r;
  logic [15:0] z_two_r, z_three_r, z_four_r, xyz_one_r;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_pair_r  <= '0;
      y_pair_r  <= '0;
      xy_pair_r <= '0;
      z_one_r   <= '0;
      z_two_r   <= '0;
      z_three_r <= '0;
      z_four_r  <= '0;
      xyz_one_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        mtc_pkg::REG_X_PAIR:  x_pair_r  <= pwdata[15:0];
        mtc_pkg::REG_Y_PAIR:  y_pair_r  <= pwdata[15:0];
        mtc_pkg::REG_XY_PAIR: xy_pair_r <= pwdata[15:0];
        mtc_pkg::REG_Z_ONE:   z_one_r   <= pwdata[15:0];
        mtc_pkg::REG_Z_TWO:   z_two_r   <= pwdata[15:0];
        mtc_pkg::REG_Z_THREE: z_three_r <= pwdata[15:0];
        mtc_pkg::REG_Z_FOUR:  z_four_r  <= pwdata[15:0];
        mtc_pkg::REG_XYZ_ONE: xyz_one_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      mtc_pkg::REG_X_PAIR:  prdata[15:0] = x_pair_r;
      mtc_pkg::REG_Y_PAIR:  prdata[15:0] = y_pair_r;
      mtc_pkg::REG_XY_PAIR: prdata[15:0] = xy_pair_r;
      mtc_pkg::REG_Z_ONE:   prdata[15:0] = z_one_r;
      mtc_pkg::REG_Z_TWO:   prdata[15:0] = z_two_r;
      mtc_pkg::REG_Z_THREE: prdata[15:0] = z_three_r;
      mtc_pkg::REG_Z_FOUR:  prdata[15:0] = z_four_r;
      mtc_pkg::REG_XYZ_ONE: prdata[15:0] = xyz_one_r;
      default: prdata = '0;
    endcase
  end

  // pipeline control
  logic adv;
  logic vld_a_r, vld_b_r, vld_c_r, vld_d_r, vld_e_r, vld_f_r, vld_g_r, vld_h_r, vld_i_r;
  logic vld_dly_r [LAT];

  assign adv      = !vld_i_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
      vld_d_r <= 1'b0;
      vld_e_r <= 1'b0;
      vld_f_r <= 1'b0;
      vld_g_r <= 1'b0;
      vld_h_r <= 1'b0;
      vld_i_r <= 1'b0;
      for (int i = 0; i < LAT; i++) vld_dly_r[i] <= 1'b0;
    end else if (adv) begin
      vld_a_r      <= in_valid;
      vld_b_r      <= vld_a_r;
      vld_c_r      <= vld_b_r;
      vld_dly_r[0] <= vld_c_r;
      for (int i = 1; i < LAT; i++) vld_dly_r[i] <= vld_dly_r[i-1];
      vld_d_r      <= vld_dly_r[LAT-1];
      vld_e_r      <= vld_d_r;
      vld_f_r      <= vld_e_r;
      vld_g_r      <= vld_f_r;
      vld_h_r      <= vld_g_r;
      vld_i_r      <= vld_h_r;
    end
  end

  // stage A: field extraction
  logic               rdy_a_r;
  logic signed [12:0] mx_a_r, my_a_r;
  logic signed [14:0] mz_a_r;
  logic [13:0]        r_a_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      rdy_a_r <= in_word_hall[0];
      mx_a_r  <= $signed(in_word_x[15:3]);
      my_a_r  <= $signed(in_word_y[15:3]);
      mz_a_r  <= $signed(in_word_z[15:1]);
      r_a_r   <= in_word_hall[15:2];
    end
  end

  // stage B: z products, resistance divisor
  logic signed [17:0] dz;
  logic signed [33:0] pz3_full;
  logic [30:0]        pz1_full;
  logic signed [16:0] mzd;
  logic [15:0]        dr;
  mtc_pkg::side_t     side_b_r;
  logic signed [31:0] pz3_b_r;
  logic [30:0]        pz1_b_r;
  logic signed [16:0] mzd_b_r;
  logic [15:0]        dr_b_r;

  assign dz       = $signed({4'b0, r_a_r}) - $signed({{2{xyz_one_r[15]}}, xyz_one_r});
  assign pz3_full = $signed(z_three_r) * dz;
  assign pz1_full = z_one_r * {1'b0, r_a_r, 1'b0};
  assign mzd      = $signed({{2{mz_a_r[14]}}, mz_a_r}) - $signed({z_four_r[15], z_four_r});
  assign dr       = (r_a_r != '0) ? {2'b0, r_a_r} : xyz_one_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      side_b_r.rdy      <= rdy_a_r;
      side_b_r.mx       <= mx_a_r;
      side_b_r.my       <= my_a_r;
      side_b_r.dr_zero  <= (dr == '0);
      side_b_r.z_neg    <= 1'b0;
      side_b_r.den_zero <= 1'b0;
      pz3_b_r           <= pz3_full[31:0];
      pz1_b_r           <= pz1_full;
      mzd_b_r           <= mzd;
      dr_b_r            <= dr;
    end
  end

  // stage C: z numerator and divisor magnitudes, temperature divide operands
  logic [31:0]        num;
  logic signed [31:0] pz3_sh;
  logic [31:0]        rsum;
  logic signed [16:0] den;
  mtc_pkg::side_t     side_c_r;
  logic [31:0]        un_c_r;
  logic [16:0]        ud_c_r;
  logic [31:0]        numq_c_r;
  logic [16:0]        drq_c_r;

  assign pz3_sh = pz3_b_r >>> 2;
  assign num    = {mzd_b_r, 15'b0} - pz3_sh;
  assign rsum   = {1'b0, pz1_b_r} + mtc_pkg::ROUND_HALF;
  assign den    = $signed({z_two_r[15], z_two_r}) + $signed({1'b0, rsum[31:16]});

  always_ff @(posedge clk) begin
    if (adv) begin
      side_c_r.rdy      <= side_b_r.rdy;
      side_c_r.mx       <= side_b_r.mx;
      side_c_r.my       <= side_b_r.my;
      side_c_r.dr_zero  <= side_b_r.dr_zero;
      side_c_r.z_neg    <= num[31] ^ den[16];
      side_c_r.den_zero <= (den == '0);
      un_c_r            <= num[31] ? (32'd0 - num) : num;
      ud_c_r            <= den[16] ? (17'd0 - den) : den;
      numq_c_r          <= {2'b0, xyz_one_r, 14'b0};
      drq_c_r           <= {1'b0, dr_b_r};
    end
  end

  // dividers and matching sideband line
  logic [31:0]    quo_q, quo_z;
  mtc_pkg::side_t side_dly_r [LAT];

  mtc_div #(.NUM_W(mtc_pkg::DIV_NUM_W), .DEN_W(mtc_pkg::DIV_DEN_W)) u_div_q (
    .clk   (clk),
    .en    (adv),
    .num_i (numq_c_r),
    .den_i (drq_c_r),
    .quo_o (quo_q)
  );

  mtc_div #(.NUM_W(mtc_pkg::DIV_NUM_W), .DEN_W(mtc_pkg::DIV_DEN_W)) u_div_z (
    .clk   (clk),
    .en    (adv),
    .num_i (un_c_r),
    .den_i (ud_c_r),
    .quo_o (quo_z)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      side_dly_r[0] <= side_c_r;
      for (int i = 1; i < LAT; i++) side_dly_r[i] <= side_dly_r[i-1];
    end
  end

  // stage D: temperature term, signed z
  mtc_pkg::side_t     side_d_r;
  logic signed [15:0] temp_d_r;
  logic signed [15:0] fz_d_r;
  logic [15:0]        qz16;
  logic [15:0]        tq;

  assign qz16 = side_dly_r[LAT-1].z_neg ? (16'd0 - quo_z[15:0]) : quo_z[15:0];
  assign tq   = (side_dly_r[LAT-1].dr_zero ? 16'd0 : quo_q[15:0]) - mtc_pkg::TEMP_BIAS;

  always_ff @(posedge clk) begin
    if (adv) begin
      side_d_r <= side_dly_r[LAT-1];
      temp_d_r <= $signed(tq);
      fz_d_r   <= side_dly_r[LAT-1].den_zero ? 16'sd0 : $signed(qz16);
    end
  end

  // stage E: square and linear terms
  logic signed [31:0] tsq, bterm;
  logic signed [15:0] xy1s;
  mtc_pkg::side_t     side_e_r;
  logic signed [31:0] sq_e_r, b_e_r;
  logic signed [15:0] fz_e_r;

  assign xy1s  = $signed({1'b0, xy_pair_r[7:0], 7'b0});
  assign tsq   = temp_d_r * temp_d_r;
  assign bterm = temp_d_r * xy1s;

  always_ff @(posedge clk) begin
    if (adv) begin
      side_e_r <= side_d_r;
      sq_e_r   <= tsq >>> 7;
      b_e_r    <= bterm;
      fz_e_r   <= fz_d_r;
    end
  end

  // stage F: xy2 scaling
  logic signed [39:0] a_full;
  mtc_pkg::side_t     side_f_r;
  logic signed [31:0] a_f_r, b_f_r;
  logic signed [15:0] fz_f_r;

  assign a_full = $signed(xy_pair_r[15:8]) * sq_e_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      side_f_r <= side_e_r;
      a_f_r    <= a_full[31:0];
      b_f_r    <= b_e_r;
      fz_f_r   <= fz_e_r;
    end
  end

  // stage G: sensitivity sum
  logic signed [31:0] ab_sum, ab_sh;
  mtc_pkg::side_t     side_g_r;
  logic signed [31:0] s_g_r;
  logic signed [15:0] fz_g_r;

  assign ab_sum = a_f_r + b_f_r;
  assign ab_sh  = ab_sum >>> 9;

  always_ff @(posedge clk) begin
    if (adv) begin
      side_g_r <= side_f_r;
      s_g_r    <= ab_sh + $signed(mtc_pkg::SENS_BIAS);
      fz_g_r   <= fz_f_r;
    end
  end

  // stage H: per-axis gain
  logic signed [9:0]  gadj_x, gadj_y;
  logic signed [41:0] gx_full, gy_full;
  mtc_pkg::side_t     side_h_r;
  logic signed [31:0] gx_h_r, gy_h_r;
  logic signed [15:0] fz_h_r;

  assign gadj_x  = $signed({{2{x_pair_r[15]}}, x_pair_r[15:8]}) + mtc_pkg::GAIN_BIAS;
  assign gadj_y  = $signed({{2{y_pair_r[15]}}, y_pair_r[15:8]}) + mtc_pkg::GAIN_BIAS;
  assign gx_full = s_g_r * gadj_x;
  assign gy_full = s_g_r * gadj_y;

  always_ff @(posedge clk) begin
    if (adv) begin
      side_h_r <= side_g_r;
      gx_h_r   <= gx_full[31:0];
      gy_h_r   <= gy_full[31:0];
      fz_h_r   <= fz_g_r;
    end
  end

  // stage I: apply to raw axes, offset, output register
  logic signed [31:0] gx_sh, gy_sh;
  logic signed [44:0] px_full, py_full;
  logic signed [31:0] px, py, fx_sh, fy_sh;
  logic [15:0]        offx, offy, fx, fy;

  assign gx_sh   = gx_h_r >>> 12;
  assign gy_sh   = gy_h_r >>> 12;
  assign px_full = side_h_r.mx * gx_sh;
  assign py_full = side_h_r.my * gy_sh;
  assign px      = px_full[31:0];
  assign py      = py_full[31:0];
  assign fx_sh   = px >>> 13;
  assign fy_sh   = py >>> 13;
  assign offx    = {{5{x_pair_r[7]}}, x_pair_r[7:0], 3'b0};
  assign offy    = {{5{y_pair_r[7]}}, y_pair_r[7:0], 3'b0};
  assign fx      = fx_sh[15:0] + offx;
  assign fy      = fy_sh[15:0] + offy;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ready_res <= side_h_r.rdy;
      out_field_x   <= side_h_r.rdy ? $signed(fx) : 16'sd0;
      out_field_y   <= side_h_r.rdy ? $signed(fy) : 16'sd0;
      out_field_z   <= side_h_r.rdy ? fz_h_r : 16'sd0;
      out_div_fault <= side_h_r.rdy & (side_h_r.dr_zero | side_h_r.den_zero);
    end
  end

  assign out_valid = vld_i_r;

`ifndef SYNTHESIS
  a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready_res |->
      out_field_x == 16'sd0 && out_field_y == 16'sd0 && out_field_z == 16'sd0
      && !out_div_fault)
    else $error("not-ready beat carries nonzero fields");

  a_fault_needs_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_fault |-> out_ready_res)
    else $error("divide fault on a not-ready beat");

  a_stall_holds_div: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> $stable(vld_dly_r[LAT-1]) && $stable(vld_c_r))
    else $error("pipeline moved during stall");

  a_den_zero_z: assert property (@(posedge clk) disable iff (!rst_n)
    vld_e_r && side_e_r.den_zero |-> fz_e_r == 16'sd0)
    else $error("zero z divisor gave nonzero z");
`endif

endmodule

// ===== verif/magnetometer_trim_compensation_top_tb.sv =====
// Self-checking testbench for the magnetometer trim compensation top level.
`timescale 1ns / 100ps

module magnetometer_trim_compensation_top_tb;

  typedef struct {
    bit      rdy;
    shortint fx;
    shortint fy;
    shortint fz;
    bit      flt;
  } field_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_word_x;
  logic [15:0] in_word_y;
  logic [15:0] in_word_z;
  logic [15:0] in_word_hall;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_ready_res;
  logic signed [15:0] out_field_x;
  logic signed [15:0] out_field_y;
  logic signed [15:0] out_field_z;
  logic        out_div_fault;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [mtc_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [15:0] trims [8];
  field_res_t  pending_fields [$];
  int          err_cnt;
  int          quiet_cycles = 0;
  bit          no_idle;
  int          stall_left = 0;

  magnetometer_trim_compensation_top u_top (.*);

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int w16(int v);
    return {{16{v[15]}}, v[15:0]};
  endfunction

  function automatic int s8(logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

  function automatic int comp_axis(int raw, int temp, int xy1, int xy2, int gain, int offs);
    int sq, a, b, s, g, f;
    sq = (temp * temp) >>> 7;
    a  = xy2 * sq;
    b  = temp * w16(xy1 << 7);
    s  = ((a + b) >>> 9) + 32'sh0010_0000;
    g  = s * (gain + 160);
    f  = (raw * (g >>> 12)) >>> 13;
    return w16(w16(f) + (offs << 3));
  endfunction

  function automatic field_res_t compensate(logic [15:0] wx, logic [15:0] wy,
                                            logic [15:0] wz, logic [15:0] wh);
    field_res_t res;
    int mx, my, mz, r, xyz1, dr, q, temp, num, den;
    res = '{0, 0, 0, 0, 0};
    if (!wh[0]) return res;
    mx   = {{19{wx[15]}}, wx[15:3]};
    my   = {{19{wy[15]}}, wy[15:3]};
    mz   = {{17{wz[15]}}, wz[15:1]};
    r    = wh[15:2];
    xyz1 = trims[mtc_pkg::REG_XYZ_ONE];
    dr   = (r != 0) ? r : xyz1;
    if (dr == 0) begin
      res.flt = 1'b1;
      q = 0;
    end else begin
      q = (xyz1 << 14) / dr;
    end
    temp = w16(int'(q[15:0]) - 16384);
    res.rdy = 1'b1;
    res.fx = shortint'(comp_axis(mx, temp, trims[mtc_pkg::REG_XY_PAIR][7:0],
                                 s8(trims[mtc_pkg::REG_XY_PAIR][15:8]),
                                 s8(trims[mtc_pkg::REG_X_PAIR][15:8]),
                                 s8(trims[mtc_pkg::REG_X_PAIR][7:0])));
    res.fy = shortint'(comp_axis(my, temp, trims[mtc_pkg::REG_XY_PAIR][7:0],
                                 s8(trims[mtc_pkg::REG_XY_PAIR][15:8]),
                                 s8(trims[mtc_pkg::REG_Y_PAIR][15:8]),
                                 s8(trims[mtc_pkg::REG_Y_PAIR][7:0])));
    num = ((mz - w16(trims[mtc_pkg::REG_Z_FOUR])) << 15)
        - ((w16(trims[mtc_pkg::REG_Z_THREE]) * (r - w16(trims[mtc_pkg::REG_XYZ_ONE]))) >>> 2);
    den = w16(trims[mtc_pkg::REG_Z_TWO])
        + w16(((int'(trims[mtc_pkg::REG_Z_ONE]) * (r << 1)) + 32768) >>> 16);
    if (den == 0) begin
      res.flt = 1'b1;
      res.fz = 0;
    end else if (num == 32'sh8000_0000 && den == -1) begin
      res.fz = 0;
    end else begin
      res.fz = shortint'(w16(num / den));
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_frame(logic [15:0] wx, logic [15:0] wy, logic [15:0] wz,
                            logic [15:0] wh);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_word_x    <= wx;
    in_word_y    <= wy;
    in_word_z    <= wz;
    in_word_hall <= wh;
    do @(posedge clk); while (!in_ready);
    pending_fields.push_back(compensate(wx, wy, wz, wh));
  endtask

  // waits for the pipe to empty before touching trims
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_fields.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_trim(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    trims[idx] = val;
  endtask

  task automatic load_trims(logic [15:0] xp, logic [15:0] yp, logic [15:0] xyp,
                            logic [15:0] z1, logic [15:0] z2, logic [15:0] z3,
                            logic [15:0] z4, logic [15:0] xyz1);
    drain();
    write_trim(mtc_pkg::REG_X_PAIR, xp);
    write_trim(mtc_pkg::REG_Y_PAIR, yp);
    write_trim(mtc_pkg::REG_XY_PAIR, xyp);
    write_trim(mtc_pkg::REG_Z_ONE, z1);
    write_trim(mtc_pkg::REG_Z_TWO, z2);
    write_trim(mtc_pkg::REG_Z_THREE, z3);
    write_trim(mtc_pkg::REG_Z_FOUR, z4);
    write_trim(mtc_pkg::REG_XYZ_ONE, xyz1);
  endtask

  task automatic send_random_frame();
    logic [15:0] wh;
    int sel;
    wh = 16'($urandom);
    wh[0] = ($urandom_range(0, 99) < 85);
    sel = $urandom_range(0, 9);
    if (sel == 0) wh[15:2] = '0;
    else if (sel < 6)
      wh[15:2] = 14'(trims[mtc_pkg::REG_XYZ_ONE][13:0] + $urandom_range(0, 1200) - 600);
    send_frame(16'($urandom), 16'($urandom), 16'($urandom), wh);
  endtask

  task automatic test_reset_trims();
    send_frame(16'h1234, 16'hFFF8, 16'h0002, 16'h2001);
    send_frame(16'h0000, 16'h0000, 16'h0000, 16'h0001);
  endtask

  task automatic test_special_cases();
    load_trims(16'h1AFE, 16'h19FF, 16'hE41D, 16'd24000, 16'd700, -16'sd300,
               16'd0, 16'd6800);
    send_frame(16'h7FF8, 16'h8000, 16'h7FFE, 16'h6A41);
    send_frame(16'h8000, 16'h7FF8, 16'h8000, 16'h6A41);
    send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_frame(16'h0000, 16'h0000, 16'h0000, 16'h0001);
    send_frame(16'h1238, 16'hFE10, 16'h0452, 16'h6A40);
    send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE);
    send_frame(16'h1238, 16'hFE10, 16'h0452, 16'h0001);
    send_frame(16'h1238, 16'hFE10, 16'h0452, 16'h0003);
    // zero resistance with zero xyz1, and zero z divisor
    load_trims(16'h1AFE, 16'h19FF, 16'hE41D, 16'd0, 16'd0, -16'sd300, 16'd0, 16'd0);
    send_frame(16'h1238, 16'hFE10, 16'h0452, 16'h0001);
    send_frame(16'h7FF8, 16'h8000, 16'h7FFE, 16'hFFFD);
    send_frame(16'h8000, 16'h7FF8, 16'h8000, 16'h0005);
    // z divisor of minus one
    load_trims(16'h1AFE, 16'h19FF, 16'hE41D, 16'd0, 16'hFFFF, 16'h7FFF, 16'h8000, 16'd0);
    send_frame(16'h7FF8, 16'h8000, 16'h7FFE, 16'hFFFD);
    send_frame(16'h8000, 16'h7FF8, 16'h8000, 16'h0005);
  endtask

  task automatic test_trim_extremes();
    load_trims(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF,
               16'h7FFF, 16'hFFFF);
    repeat (60) send_random_frame();
    load_trims(16'h8080, 16'h8080, 16'h8000, 16'h0000, 16'h8000, 16'h8000,
               16'h8000, 16'h0000);
    repeat (60) send_random_frame();
    load_trims(16'h7F7F, 16'h7F7F, 16'h7FFF, 16'hFFFF, 16'h8000, 16'h7FFF,
               16'h8000, 16'h3FFF);
    repeat (40) send_random_frame();
  endtask

  task automatic test_random_trims();
    repeat (10) begin
      if ($urandom_range(0, 2) == 0)
        load_trims($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom);
      else
        load_trims($urandom, $urandom, $urandom, $urandom_range(20000, 30000),
                   $urandom_range(0, 2000), $urandom_range(0, 2000) - 1000,
                   $urandom_range(0, 200) - 100, $urandom_range(5000, 8000));
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (100) send_random_frame();
      no_idle = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || stall_left == 0) begin
      out_ready <= 1'b1;
      stall_left <= (rst_n) ? pick_gap() : 0;
    end else begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    field_res_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_fields.size() == 0) begin
        $error("unexpected result beat");
        err_cnt++;
      end else begin
        exp_res = pending_fields.pop_front();
        if (out_ready_res !== exp_res.rdy) begin
          $error("ready_res exp %0d got %0d", exp_res.rdy, out_ready_res);
          err_cnt++;
        end
        if (out_field_x !== exp_res.fx) begin
          $error("field_x exp %0d got %0d", exp_res.fx, out_field_x);
          err_cnt++;
        end
        if (out_field_y !== exp_res.fy) begin
          $error("field_y exp %0d got %0d", exp_res.fy, out_field_y);
          err_cnt++;
        end
        if (out_field_z !== exp_res.fz) begin
          $error("field_z exp %0d got %0d", exp_res.fz, out_field_z);
          err_cnt++;
        end
        if (out_div_fault !== exp_res.flt) begin
          $error("div_fault exp %0d got %0d", exp_res.flt, out_div_fault);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 5000) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    err_cnt      = 0;
    no_idle      = 1'b0;
    for (int i = 0; i < 8; i++) trims[i] = 16'h0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_word_x    <= 16'h0;
    in_word_y    <= 16'h0;
    in_word_z    <= 16'h0;
    in_word_hall <= 16'h0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= 32'h0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_trims();
    test_special_cases();
    test_trim_extremes();
    test_random_trims();
    drain();
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
